[hdl/smf_pkg.sv]
package smf_pkg;

    // Item kind as classified by the front end
    typedef enum logic {
        OP_FILTER  = 1'b0,
        OP_PRELOAD = 1'b1
    } t_op;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic vld;
        t_op  op;
    } t_head;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd5;

endpackage

[hdl/sliding_window_median_filter_core.sv]
// Running median filter over a programmable sliding window.
//
// Input channel (queue style): an item transfers on a clock edge with push
// high and full low. i_op = 0 filters i_sample_value and produces one
// median; i_op = 1 preloads the whole history with i_sample_value and
// produces nothing.
// Result channel (queue style): o_median_value is valid while empty is low
// and transfers on an edge with pop high.
// Config: i_cfg_we writes i_cfg_wdata into the window length (0 acts as 1,
// values above MAX_WINDOW clamp). Write only while the block is idle.
//
// Flow: a two-entry item queue feeds the back end, which searches the
// window one candidate per cycle until it finds the one of rank length/2.
// A preload leaves the queue head as soon as it arrives there; a filter
// item leaves when its median is found and written to the output register.
// Stall: a result waits in the output register; the next filter item holds
// at its final candidate until the register frees, while the queue keeps
// taking items until full.
// Reset: history cleared to zero, window length 5, queues empty.
module sliding_window_median_filter_core #(
    parameter int MAX_WINDOW   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item channel
    input  logic                              push,
    output logic                              full,
    input  logic                              i_op,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_value,
    // result channel
    output logic                              empty,
    input  logic                              pop,
    output logic signed [SAMPLE_WIDTH-1:0]    o_median_value,
    // window length register
    input  logic                              i_cfg_we,
    input  logic [smf_pkg::CFG_W-1:0]         i_cfg_wdata
);

    logic [smf_pkg::CFG_W-1:0]      r_window_length;
    smf_pkg::t_head                 head;
    logic signed [SAMPLE_WIDTH-1:0] head_sample;
    logic                           deq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= smf_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_length <= i_cfg_wdata;
        end
    end

    // Front end: take the transfer, classify, queue
    smf_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_op          (i_op),
        .i_sample      (i_sample_value),
        .o_full        (full),
        .i_deq         (deq),
        .o_head        (head),
        .o_head_sample (head_sample)
    );

    // Back end: history, rank search, output register
    smf_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_sample   (head_sample),
        .o_deq           (deq),
        .i_window_length (r_window_length),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_median        (o_median_value)
    );

endmodule

[hdl/smf_front.sv]
module smf_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_op,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_full,
    input  logic                           i_deq,
    output smf_pkg::t_head                 o_head,
    output logic signed [SAMPLE_WIDTH-1:0] o_head_sample
);

    // Two-entry item queue
    smf_pkg::t_op               r_op   [2];
    logic signed [SAMPLE_WIDTH-1:0] r_data [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    smf_pkg::t_op op_cls;
    logic         wr_en;
    logic         rd_en;

    always_comb begin
        unique case (i_op)
            1'b1:    op_cls = smf_pkg::OP_PRELOAD;
            default: op_cls = smf_pkg::OP_FILTER;
        endcase
    end

    assign o_full = (r_count == 2'd2);
    assign wr_en  = i_push && !o_full;
    assign rd_en  = i_deq && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = wr_en ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = rd_en ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_op[r_wr_ptr]   <= op_cls;
            r_data[r_wr_ptr] <= i_sample;
        end
    end

    assign o_head.vld    = (r_count != 2'd0);
    assign o_head.op     = r_op[r_rd_ptr];
    assign o_head_sample = r_data[r_rd_ptr];

endmodule

[hdl/smf_back.sv]
module smf_back #(
    parameter int MAX_WINDOW   = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smf_pkg::t_head                    i_head,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_head_sample,
    output logic                              o_deq,
    input  logic [smf_pkg::CFG_W-1:0]         i_window_length,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [SAMPLE_WIDTH-1:0]    o_median
);

    localparam int HIST_D = MAX_WINDOW - 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (LEN_W > smf_pkg::CFG_W) ? LEN_W : smf_pkg::CFG_W;

    logic signed [SAMPLE_WIDTH-1:0] r_hist [HIST_D];
    logic signed [SAMPLE_WIDTH-1:0] n_hist [HIST_D];
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic                           r_out_vld, n_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data, n_out_data;

    logic signed [SAMPLE_WIDTH-1:0] win [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cand;
    logic [CMP_W-1:0]               wl_ext;
    logic [LEN_W-1:0]               len;
    logic [LEN_W-1:0]               rank;
    logic [MAX_WINDOW-1:0]          less;
    logic                           match;
    logic                           out_free;
    logic                           is_filter;
    logic                           is_preload;
    logic                           commit;

    // Length clamped to 1..MAX_WINDOW
    always_comb begin
        wl_ext = CMP_W'(i_window_length);
        if (wl_ext == '0) begin
            len = LEN_W'(1);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(wl_ext);
        end
    end

    // Window slot 0 is the new sample, slot k the k-th newest stored one
    always_comb begin
        win[0] = i_head_sample;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            win[k] = r_hist[k-1];
        end
    end

    assign cand = win[r_cnt];

    // Rank of the candidate; ties broken by slot so every rank is unique
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            less[k] = (LEN_W'(k) < len) &&
                      ((win[k] < cand) || ((win[k] == cand) && (CNT_W'(k) < r_cnt)));
        end
    end

    assign rank  = LEN_W'($countones(less));
    assign match = (rank == (len >> 1));

    assign out_free   = !r_out_vld || i_pop;
    assign is_filter  = i_head.vld && (i_head.op == smf_pkg::OP_FILTER);
    assign is_preload = i_head.vld && (i_head.op == smf_pkg::OP_PRELOAD);
    assign commit     = is_filter && match && out_free;
    assign o_deq      = is_preload || commit;

    always_comb begin
        n_cnt = r_cnt;
        if (o_deq) begin
            n_cnt = '0;
        end else if (is_filter && !match) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < HIST_D; k++) begin
            n_hist[k] = r_hist[k];
        end
        if (is_preload) begin
            for (int k = 0; k < HIST_D; k++) begin
                n_hist[k] = i_head_sample;
            end
        end else if (commit) begin
            n_hist[0] = i_head_sample;
            for (int k = 1; k < HIST_D; k++) begin
                n_hist[k] = r_hist[k-1];
            end
        end
    end

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        if (commit) begin
            n_out_vld  = 1'b1;
            n_out_data = cand;
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < HIST_D; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            for (int k = 0; k < HIST_D; k++) begin
                r_hist[k] <= n_hist[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_empty  = !r_out_vld;
    assign o_median = r_out_data;

endmodule

[dv/tb_sliding_window_median_filter_core.sv]
`timescale 1ns / 1ps

module tb_sliding_window_median_filter_core;

    localparam int MAX_WIN    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int HIST_DEPTH = MAX_WIN - 1;
    // settle margin covers a full back-end search plus the item queue
    localparam int SETTLE     = 2 * MAX_WIN + 8;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_LEN  = 145;
    localparam int TIMEOUT_NS = 2_000_000;

    // Expected-median tracker: a private copy of the window register and the
    // sample history, advanced on every accepted input transfer.
    class median_scoreboard;
        logic signed [SAMPLE_W-1:0]      history[HIST_DEPTH];
        logic [smf_pkg::CFG_W-1:0]       win_len;
        logic signed [SAMPLE_W-1:0]      expected_medians[$];
        int                              errors;

        function new();
            foreach (history[i]) history[i] = '0;
            win_len = smf_pkg::WINDOW_RESET;
            errors  = 0;
        endfunction

        function void set_length(logic [smf_pkg::CFG_W-1:0] v);
            win_len = v;
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction

        function void note_input(smf_pkg::t_op op, logic signed [SAMPLE_W-1:0] sample);
            logic signed [SAMPLE_W-1:0] win[MAX_WIN];
            logic signed [SAMPLE_W-1:0] v;
            int n;
            int j;
            if (op == smf_pkg::OP_PRELOAD) begin
                foreach (history[i]) history[i] = sample;
                return;
            end
            // zero acts as one, anything past the maximum clamps
            n = int'(win_len);
            if (n < 1) n = 1;
            if (n > MAX_WIN) n = MAX_WIN;
            for (int i = 0; i < n - 1; i++) win[i] = history[i];
            win[n-1] = sample;
            for (int i = 1; i < n; i++) begin
                v = win[i];
                j = i;
                while (j > 0 && win[j-1] > v) begin
                    win[j] = win[j-1];
                    j--;
                end
                win[j] = v;
            end
            expected_medians.push_back(win[n/2]);
            // full history shifts regardless of the window length
            for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = sample;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] exp_med;
            if (expected_medians.size() == 0) begin
                $error("median_value: expected none, actual %0d", actual);
                errors++;
                return;
            end
            exp_med = expected_medians.pop_front();
            if (exp_med !== actual) begin
                $error("median_value: expected %0d, actual %0d", exp_med, actual);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    smf_pkg::t_op               i_op;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] o_median_value;
    logic                       i_cfg_we;
    logic [smf_pkg::CFG_W-1:0]  i_cfg_wdata;

    median_scoreboard sb = new();

    // sender pacing
    int burst_left;
    bit steady;
    // receiver long hold-off request, cleared by the receiver when done
    bit hold_req;

    sliding_window_median_filter_core #(
        .MAX_WINDOW   (MAX_WIN),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_sample_value (i_sample_value),
        .empty          (empty),
        .pop            (pop),
        .o_median_value (o_median_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: generous bound well above the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Monitor: everything is sampled at the rising edge, before the DUT's
    // registers update, so the values seen are the ones that qualified the
    // transfer. Config writes are mirrored in the same order as the DUT sees them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_length(i_cfg_wdata);
            if (push && !full) sb.note_input(i_op, i_sample_value);
            if (pop && !empty) sb.check_result(o_median_value);
        end
    end

    // Receiver: pop pattern changes mode after a random run length (always
    // ready, coin flip, mostly stalled, square wave). On request it holds
    // off for a long stretch so the DUT backs up and raises full.
    initial begin : receiver
        int pop_mode;
        int mode_left;
        int rx_cycle;
        pop       = 1'b0;
        pop_mode  = 0;
        mode_left = 0;
        rx_cycle  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    pop_mode  = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 160);
                end
                mode_left--;
                rx_cycle++;
                case (pop_mode)
                    0: begin
                        pop <= 1'b1;
                    end
                    1: begin
                        pop <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        pop <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        pop <= rx_cycle[3];
                    end
                endcase
            end
        end
    end

    // One input transfer: drive at the falling edge, hold until the edge
    // where full was low. push stays high so back-to-back items stream.
    task automatic drive_item(input smf_pkg::t_op op,
                              input logic signed [SAMPLE_W-1:0] val);
        @(negedge i_clk);
        push           <= 1'b1;
        i_op           <= op;
        i_sample_value <= val;
        do @(posedge i_clk); while (full);
    endtask

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // Bursty sender: random burst lengths separated by random gaps,
    // unless the phase runs steady.
    task automatic send_paced(input smf_pkg::t_op op,
                              input logic signed [SAMPLE_W-1:0] val);
        if (!steady && burst_left == 0) begin
            idle_input($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        drive_item(op, val);
        if (burst_left > 0) burst_left--;
    endtask

    // Wait for every expected median, then let a trailing preload finish
    // in the back end before anything touches the register.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [smf_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Sample mix: full-range random, a narrow band that forces ties,
    // the extremes, and a mid-size cluster.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return SAMPLE_W'($urandom_range(0, 65535));
        if (sel < 70) return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
        if (sel < 85) begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return '0;
                default: return '1;
            endcase
        end
        return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    initial begin : stimulus
        int lens[12];
        int len;
        smf_pkg::t_op op;
        lens = '{3, 1, 16, 2, 8, 0, 17, 31, 4, 15, 5, -1};

        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_op           = smf_pkg::OP_FILTER;
        i_sample_value = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        burst_left     = 0;
        steady         = 1'b1;
        hold_req       = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // reset window length and zeroed history, field extremes
        drive_item(smf_pkg::OP_FILTER, 16'sd100);
        drive_item(smf_pkg::OP_FILTER, 16'sh7fff);
        drive_item(smf_pkg::OP_FILTER, 16'sh8000);
        drive_item(smf_pkg::OP_FILTER, -16'sd1);
        drive_item(smf_pkg::OP_FILTER, 16'sd1);
        drive_item(smf_pkg::OP_FILTER, 16'sh7fff);
        drain();

        // length one passes the sample through
        write_window(5'd1);
        drive_item(smf_pkg::OP_FILTER, -16'sd12345);
        drive_item(smf_pkg::OP_FILTER, 16'sh5555);
        drive_item(smf_pkg::OP_FILTER, 16'shaaaa);
        drain();

        // length zero behaves as one
        write_window(5'd0);
        drive_item(smf_pkg::OP_FILTER, 16'sd42);
        drain();

        // even length picks the upper middle element
        write_window(5'd2);
        drive_item(smf_pkg::OP_FILTER, 16'sd10);
        drive_item(smf_pkg::OP_FILTER, 16'sd20);
        // preload must reach entries outside the current window
        drive_item(smf_pkg::OP_PRELOAD, 16'sd7);
        drain();
        write_window(5'd16);
        drive_item(smf_pkg::OP_FILTER, 16'sd0);
        drive_item(smf_pkg::OP_FILTER, 16'sh8000);
        drain();

        // lengths past the maximum clamp
        write_window(5'd17);
        drive_item(smf_pkg::OP_FILTER, 16'sd1);
        drain();
        write_window(5'd31);
        drive_item(smf_pkg::OP_PRELOAD, 16'sh8000);
        drive_item(smf_pkg::OP_FILTER, 16'sh7fff);
        drain();

        // shorter window after a long one uses the newest samples
        write_window(5'd4);
        drive_item(smf_pkg::OP_FILTER, 16'sd3);
        drive_item(smf_pkg::OP_FILTER, -16'sd3);
        drain();

        // --- random phases, one window setting each ---
        foreach (lens[p]) begin
            len = (lens[p] < 0) ? $urandom_range(0, 31) : lens[p];
            write_window((smf_pkg::CFG_W)'(len));
            steady     = (p % 4 == 3) || (p == 2);
            burst_left = 0;
            // slowest setting: receiver stalls long while the sender keeps pushing
            if (p == 2) hold_req = 1'b1;
            repeat (PHASE_LEN) begin
                op = ($urandom_range(0, 99) < 8) ? smf_pkg::OP_PRELOAD
                                                 : smf_pkg::OP_FILTER;
                send_paced(op, pick_sample());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sliding_window_median_filter_core.f]
hdl/smf_pkg.sv
hdl/smf_front.sv
hdl/smf_back.sv
hdl/sliding_window_median_filter_core.sv
dv/tb_sliding_window_median_filter_core.sv
